// ----- rtl/core/ethp_pkg.sv -----
// ----------------------------------------------------------------------------
// ethp_pkg
// Types and constants shared by the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
package ethp_pkg;

  // Fixed header sizes and match values.
  localparam logic [7:0]  ETH_HDR_BYTES = 8'd14;
  localparam logic [7:0]  MIN_HDR_BYTES = 8'd20;
  localparam logic [15:0] TYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;

  // Status codes of a parsed frame.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
  localparam logic [2:0] ST_NOT_TCP   = 3'd3;
  localparam logic [2:0] ST_BAD_IPHL  = 3'd4;
  localparam logic [2:0] ST_BAD_TCPHL = 3'd5;

  // Everything captured from one frame, as handed from capture to check.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [47:0] mac_dest;
    logic [47:0] mac_src;
    logic [15:0] eth_type;
    logic [3:0]  ip_hlen_words;
    logic [15:0] ip_tot_len;
    logic [7:0]  ip_proto;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [3:0]  tcp_offset_words;
    logic [15:0] port_src;
    logic [15:0] port_dst;
  } frame_rec_t;

endpackage

// ----- rtl/core/ethp_capture.sv -----
// ----------------------------------------------------------------------------
// ethp_capture
// Byte counter and header field capture for the frame in progress.
// ----------------------------------------------------------------------------
module ethp_capture #(
  parameter int MAX_CAPTURE_BYTES = 65535
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  input  logic [7:0]            byte_data,
  input  logic                  byte_end,
  output logic                  byte_take,
  output logic                  rec_valid,
  input  logic                  rec_ready,
  output ethp_pkg::frame_rec_t  rec
);
  import ethp_pkg::*;

  localparam logic [15:0] MAX_CNT = 16'(MAX_CAPTURE_BYTES);

  frame_rec_t st_r;
  frame_rec_t st_nxt;
  logic [15:0] pos;
  logic [15:0] tcp_base;
  logic [15:0] tcp_off;
  logic        in_range;

  // A byte that ends a frame needs room in the check stage.
  assign byte_take = byte_valid && (!byte_end || rec_ready);
  assign rec_valid = byte_valid && byte_end;
  assign rec       = st_nxt;

  assign pos      = st_r.byte_count;
  assign in_range = (pos < MAX_CNT);
  assign tcp_base = 16'(ETH_HDR_BYTES) + {10'd0, st_r.ip_hlen_words, 2'b00};
  assign tcp_off  = pos - tcp_base;

  // Next capture state, with the current byte placed by its position.
  always_comb begin
    st_nxt = st_r;
    if (in_range) begin
      st_nxt.byte_count = pos + 16'd1;
      if (pos < 16'd6) begin
        st_nxt.mac_dest = {st_r.mac_dest[39:0], byte_data};
      end else if (pos < 16'd12) begin
        st_nxt.mac_src = {st_r.mac_src[39:0], byte_data};
      end else if (pos < 16'd14) begin
        st_nxt.eth_type = {st_r.eth_type[7:0], byte_data};
      end else if (pos == 16'd14) begin
        st_nxt.ip_hlen_words = byte_data[3:0];
      end else if (pos == 16'd16 || pos == 16'd17) begin
        st_nxt.ip_tot_len = {st_r.ip_tot_len[7:0], byte_data};
      end else if (pos == 16'd23) begin
        st_nxt.ip_proto = byte_data;
      end else if (pos >= 16'd26 && pos < 16'd30) begin
        st_nxt.ip_src = {st_r.ip_src[23:0], byte_data};
      end else if (pos >= 16'd30 && pos < 16'd34) begin
        st_nxt.ip_dst = {st_r.ip_dst[23:0], byte_data};
      end

      // TCP fields follow the stored IP header length and may overlap IP fields.
      if (pos >= tcp_base) begin
        if (tcp_off < 16'd2) begin
          st_nxt.port_src = {st_r.port_src[7:0], byte_data};
        end else if (tcp_off < 16'd4) begin
          st_nxt.port_dst = {st_r.port_dst[7:0], byte_data};
        end else if (tcp_off == 16'd12) begin
          st_nxt.tcp_offset_words = byte_data[7:4];
        end
      end
    end
  end

  // State register, cleared after each frame end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (byte_take) begin
      if (byte_end) begin
        st_r <= '0;
      end else begin
        st_r <= st_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/ethp_check.sv -----
// ----------------------------------------------------------------------------
// ethp_check
// Frame record register, header checks and the result register.
// ----------------------------------------------------------------------------
module ethp_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rec_valid,
  output logic                  rec_ready,
  input  ethp_pkg::frame_rec_t  rec,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_parse_status,
  output logic [47:0]           out_dest_mac,
  output logic [47:0]           out_source_mac,
  output logic [31:0]           out_source_ip,
  output logic [31:0]           out_dest_ip,
  output logic [15:0]           out_source_port,
  output logic [15:0]           out_dest_port,
  output logic [15:0]           out_payload_length
);
  import ethp_pkg::*;

  frame_rec_t  rec_r;
  logic        rec_v_r;
  logic        out_v_r;
  logic        out_free;
  logic        rec_load;
  logic [15:0] caplen;
  logic [15:0] ip_len;
  logic [15:0] tcp_len;
  logic [15:0] hdrs;
  logic [15:0] room;
  logic [15:0] pay_raw;
  logic [2:0]  status_nxt;
  logic [15:0] pay_nxt;

  assign out_free  = !out_v_r || !out_stall;
  assign rec_ready = !rec_v_r || out_free;
  assign rec_load  = rec_valid && rec_ready;
  assign out_valid = out_v_r;

  // Header lengths in bytes.
  assign caplen  = rec_r.byte_count;
  assign ip_len  = {10'd0, rec_r.ip_hlen_words, 2'b00};
  assign tcp_len = {10'd0, rec_r.tcp_offset_words, 2'b00};
  assign hdrs    = 16'(ETH_HDR_BYTES) + ip_len + tcp_len;
  assign room    = caplen - hdrs;
  assign pay_raw = (rec_r.ip_tot_len > ip_len + tcp_len) ?
                   (rec_r.ip_tot_len - ip_len - tcp_len) : 16'd0;

  // Checks in order; the first failure decides the status.
  always_comb begin
    pay_nxt = 16'd0;
    priority if (caplen < 16'(ETH_HDR_BYTES)) begin
      status_nxt = ST_SHORT;
    end else if (rec_r.eth_type != TYPE_IPV4) begin
      status_nxt = ST_NOT_IPV4;
    end else if (caplen < 16'(ETH_HDR_BYTES) + 16'(MIN_HDR_BYTES)) begin
      status_nxt = ST_SHORT;
    end else if (rec_r.ip_proto != PROTO_TCP) begin
      status_nxt = ST_NOT_TCP;
    end else if (ip_len < 16'(MIN_HDR_BYTES)) begin
      status_nxt = ST_BAD_IPHL;
    end else if (caplen < 16'(ETH_HDR_BYTES) + ip_len + 16'(MIN_HDR_BYTES)) begin
      status_nxt = ST_SHORT;
    end else if (tcp_len < 16'(MIN_HDR_BYTES)) begin
      status_nxt = ST_BAD_TCPHL;
    end else if (caplen < hdrs) begin
      status_nxt = ST_SHORT;
    end else begin
      status_nxt = ST_OK;
      pay_nxt    = (pay_raw > room) ? room : pay_raw;
    end
  end

  // Valid flags of the record and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rec_ready) begin
        rec_v_r <= rec_valid;
      end
      if (out_free) begin
        out_v_r <= rec_v_r;
      end
    end
  end

  // Payload of the record and result registers.
  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec_r <= rec;
    end
    if (out_free && rec_v_r) begin
      out_parse_status   <= status_nxt;
      out_dest_mac       <= rec_r.mac_dest;
      out_source_mac     <= rec_r.mac_src;
      out_source_ip      <= rec_r.ip_src;
      out_dest_ip        <= rec_r.ip_dst;
      out_source_port    <= rec_r.port_src;
      out_dest_port      <= rec_r.port_dst;
      out_payload_length <= pay_nxt;
    end
  end

endmodule

// ----- rtl/core/eth_ipv4_tcp_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser_top
// Parses Ethernet, IPv4 and TCP headers from a byte stream, one result a frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one frame byte per item (in_frame_byte) with
//   in_frame_end marking the last byte. An item is taken on a clock edge with
//   in_valid high and in_stall low; one byte can be taken in every cycle while in_stall stays low.
//   The result channel carries one item per frame: status, Ethernet and IPv4
//   addresses, TCP ports and payload length, held while out_stall is high.
//   The result of a frame passes through the input register, the frame record
//   register and the result register, in that order. While in_stall is
//   low, throughput is one byte per cycle.
//   When the receiver stalls, one finished frame waits in the result register
//   and another in the record register; bytes in the middle of a frame are
//   still taken, and only a frame's last byte waits for room, raising in_stall.
//   Bytes past MAX_CAPTURE_BYTES are neither counted nor captured.
//   Reset clears all captured state and empties every register stage.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_header_parser_top #(
  parameter int MAX_CAPTURE_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_parse_status,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_source_mac,
  output logic [31:0] out_source_ip,
  output logic [31:0] out_dest_ip,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [15:0] out_payload_length
);
  import ethp_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       byte_take;
  logic       rec_valid;
  logic       rec_ready;
  frame_rec_t rec;

  // The input register holds its item until the capture stage takes it.
  assign in_stall = in_v_r && !byte_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_frame_byte;
      in_end_r  <= in_frame_end;
    end
  end

  // Field capture for the frame in progress.
  ethp_capture #(
    .MAX_CAPTURE_BYTES(MAX_CAPTURE_BYTES)
  ) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(in_v_r),
    .byte_data (in_byte_r),
    .byte_end  (in_end_r),
    .byte_take (byte_take),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  // Header checks and the result register.
  ethp_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .rec_valid         (rec_valid),
    .rec_ready         (rec_ready),
    .rec               (rec),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_parse_status  (out_parse_status),
    .out_dest_mac      (out_dest_mac),
    .out_source_mac    (out_source_mac),
    .out_source_ip     (out_source_ip),
    .out_dest_ip       (out_dest_ip),
    .out_source_port   (out_source_port),
    .out_dest_port     (out_dest_port),
    .out_payload_length(out_payload_length)
  );

endmodule

// ----- verif/tb_eth_ipv4_tcp_header_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eth_ipv4_tcp_header_parser_top
// Self-checking bench for the Ethernet/IPv4/TCP header parser.
// Frames are broken into byte items and fed through a queue to a clocked
// driver. A behavioural parser follows every accepted byte and keeps one
// expected header result for each frame. A clocked monitor compares every
// result item from the block, field by field, with the oldest expectation.
// The run opens with directed frames that cover each status and the length
// corner cases. It then sends mostly well-formed random frames, with some
// damaged frames and some noise, over phases of sender idling and receiver
// stalling. One long receiver hold-off lets the block fill up and stall its
// input.
// ----------------------------------------------------------------------------
module tb_eth_ipv4_tcp_header_parser_top;
  import ethp_pkg::*;

  localparam int unsigned CAPTURE_LIMIT = 65535;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
  } header_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_frame_byte = '0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_parse_status;
  logic [47:0] out_dest_mac;
  logic [47:0] out_source_mac;
  logic [31:0] out_source_ip;
  logic [31:0] out_dest_ip;
  logic [15:0] out_source_port;
  logic [15:0] out_dest_port;
  logic [15:0] out_payload_length;

  eth_ipv4_tcp_header_parser_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_frame_byte      (in_frame_byte),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_parse_status   (out_parse_status),
    .out_dest_mac       (out_dest_mac),
    .out_source_mac     (out_source_mac),
    .out_source_ip      (out_source_ip),
    .out_dest_ip        (out_dest_ip),
    .out_source_port    (out_source_port),
    .out_dest_port      (out_dest_port),
    .out_payload_length (out_payload_length)
  );

  // Clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes waiting to be driven, and header results waiting to be seen.
  wire_byte_t     wire_bytes[$];
  header_result_t expected_headers[$];
  logic [7:0]     frame_buf[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int frames_checked = 0;

  wire_byte_t     next_item;
  header_result_t want;

  // Captured header state of the frame in progress.
  logic [15:0] cap_count;
  logic [47:0] cap_mac_dst;
  logic [47:0] cap_mac_src;
  logic [15:0] cap_ethertype;
  logic [3:0]  cap_ihl;
  logic [15:0] cap_total_len;
  logic [7:0]  cap_proto;
  logic [31:0] cap_ip_src;
  logic [31:0] cap_ip_dst;
  logic [3:0]  cap_doff;
  logic [15:0] cap_sport;
  logic [15:0] cap_dport;

  task automatic clear_capture();
    cap_count = '0;
    cap_mac_dst = '0;
    cap_mac_src = '0;
    cap_ethertype = '0;
    cap_ihl = '0;
    cap_total_len = '0;
    cap_proto = '0;
    cap_ip_src = '0;
    cap_ip_dst = '0;
    cap_doff = '0;
    cap_sport = '0;
    cap_dport = '0;
  endtask

  initial clear_capture();

  // Follows one accepted byte; on the last byte of a frame it queues the
  // expected header result and starts afresh.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned pos, tcp_base, ip_len, tcp_len, hdrs, caplen, plen;
    header_result_t r;
    if (cap_count < CAPTURE_LIMIT) begin
      pos = cap_count;
      // The TCP header position follows the IP header length stored so far.
      tcp_base = ETH_HDR_BYTES + 4 * cap_ihl;
      if (pos < 6) cap_mac_dst = {cap_mac_dst[39:0], b};
      else if (pos < 12) cap_mac_src = {cap_mac_src[39:0], b};
      else if (pos < 14) cap_ethertype = {cap_ethertype[7:0], b};
      else if (pos == 14) cap_ihl = b[3:0];
      else if (pos == 16 || pos == 17) cap_total_len = {cap_total_len[7:0], b};
      else if (pos == 23) cap_proto = b;
      else if (pos >= 26 && pos < 30) cap_ip_src = {cap_ip_src[23:0], b};
      else if (pos >= 30 && pos < 34) cap_ip_dst = {cap_ip_dst[23:0], b};
      if (pos >= tcp_base) begin
        if (pos - tcp_base < 2) cap_sport = {cap_sport[7:0], b};
        else if (pos - tcp_base < 4) cap_dport = {cap_dport[7:0], b};
        else if (pos - tcp_base == 12) cap_doff = b[7:4];
      end
      cap_count = cap_count + 16'd1;
    end
    if (last) begin
      caplen = cap_count;
      ip_len = 4 * cap_ihl;
      tcp_len = 4 * cap_doff;
      hdrs = ETH_HDR_BYTES + ip_len + tcp_len;
      r.payload_length = '0;
      // Checks in a fixed order; the first one that fails sets the status.
      if (caplen < ETH_HDR_BYTES) r.status = ST_SHORT;
      else if (cap_ethertype != TYPE_IPV4) r.status = ST_NOT_IPV4;
      else if (caplen < ETH_HDR_BYTES + MIN_HDR_BYTES) r.status = ST_SHORT;
      else if (cap_proto != PROTO_TCP) r.status = ST_NOT_TCP;
      else if (ip_len < MIN_HDR_BYTES) r.status = ST_BAD_IPHL;
      else if (caplen < ETH_HDR_BYTES + ip_len + MIN_HDR_BYTES) r.status = ST_SHORT;
      else if (tcp_len < MIN_HDR_BYTES) r.status = ST_BAD_TCPHL;
      else if (caplen < hdrs) r.status = ST_SHORT;
      else begin
        r.status = ST_OK;
        plen = (cap_total_len > ip_len + tcp_len) ? cap_total_len - ip_len - tcp_len : 0;
        if (plen > caplen - hdrs) plen = caplen - hdrs;
        r.payload_length = plen[15:0];
      end
      r.dest_mac = cap_mac_dst;
      r.source_mac = cap_mac_src;
      r.source_ip = cap_ip_src;
      r.dest_ip = cap_ip_dst;
      r.source_port = cap_sport;
      r.dest_port = cap_dport;
      expected_headers.push_back(r);
      clear_capture();
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("frame %0d: %s expected %0h, got %0h", frames_checked, name, exp_val, got_val);
    end
  endtask

  // Driver: takes the next byte once the current one has been accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_byte(in_frame_byte, in_frame_end);
      if (!in_valid || !in_stall) begin
        if (wire_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = wire_bytes.pop_front();
          in_valid <= 1'b1;
          in_frame_byte <= next_item.data;
          in_frame_end <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_taken <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= hold_requests;
    end
  end

  // Monitor: checks each accepted result and picks the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_headers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result item with no frame outstanding, status %0d", out_parse_status);
        end else begin
          want = expected_headers.pop_front();
          compare_field("parse_status", 64'(want.status), 64'(out_parse_status));
          compare_field("dest_mac", 64'(want.dest_mac), 64'(out_dest_mac));
          compare_field("source_mac", 64'(want.source_mac), 64'(out_source_mac));
          compare_field("source_ip", 64'(want.source_ip), 64'(out_source_ip));
          compare_field("dest_ip", 64'(want.dest_ip), 64'(out_dest_ip));
          compare_field("source_port", 64'(want.source_port), 64'(out_source_port));
          compare_field("dest_port", 64'(want.dest_port), 64'(out_dest_port));
          compare_field("payload_length", 64'(want.payload_length),
                        64'(out_payload_length));
          frames_checked++;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic add_random(input int n);
    repeat (n) frame_buf.push_back(8'($urandom));
  endtask

  task automatic fill_frame(input logic [7:0] value, input int n);
    frame_buf.delete();
    repeat (n) frame_buf.push_back(value);
  endtask

  // Lays out a frame with random addresses and filler. Headers shorter than
  // the minimum are still laid out at minimum size.
  task automatic build_frame(input logic [15:0] ethertype, input logic [7:0] proto,
                             input logic [3:0] ihl, input logic [3:0] doff,
                             input logic [15:0] total_len, input int payload);
    int ip_bytes, tcp_bytes;
    ip_bytes = (ihl < 5) ? 20 : 4 * ihl;
    tcp_bytes = (doff < 5) ? 20 : 4 * doff;
    frame_buf.delete();
    add_random(12);
    frame_buf.push_back(ethertype[15:8]);
    frame_buf.push_back(ethertype[7:0]);
    // The version nibble is left random since the block ignores it.
    frame_buf.push_back({4'($urandom), ihl});
    add_random(1);
    frame_buf.push_back(total_len[15:8]);
    frame_buf.push_back(total_len[7:0]);
    add_random(5);
    frame_buf.push_back(proto);
    add_random(ip_bytes - 10);
    add_random(12);
    frame_buf.push_back({doff, 4'($urandom)});
    add_random(tcp_bytes - 13 + payload);
  endtask

  // Queues the first keep bytes of the frame, marking the last one.
  task automatic send_frame(input int keep);
    for (int i = 0; i < keep; i++)
      wire_bytes.push_back('{data: frame_buf[i], last: (i == keep - 1)});
  endtask

  task automatic send_whole();
    send_frame(frame_buf.size());
  endtask

  // Mostly well-formed frames with random content; some damaged, some noise.
  task automatic random_frame(output int sent);
    logic [3:0]  ihl, doff;
    logic [15:0] tlen, etype;
    logic [7:0]  proto;
    int pay, hdr_len, keep;
    bit truncate, noise;
    ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : 4'd5;
    doff = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : 4'd5;
    pay = $urandom_range(24);
    hdr_len = 4 * ihl + 4 * doff;
    case ($urandom_range(4))
      0: tlen = 16'($urandom);
      1: tlen = 16'($urandom_range(hdr_len));
      2: tlen = 16'(hdr_len + pay + $urandom_range(1, 40));
      default: tlen = 16'(hdr_len + pay);
    endcase
    etype = TYPE_IPV4;
    proto = PROTO_TCP;
    truncate = 1'b0;
    noise = 1'b0;
    case ($urandom_range(19))
      0: etype = 16'($urandom);
      1: proto = 8'($urandom);
      2: ihl = 4'($urandom_range(4));
      3: doff = 4'($urandom_range(4));
      4: truncate = 1'b1;
      5: noise = 1'b1;
      default: ;
    endcase
    if (noise) begin
      frame_buf.delete();
      add_random($urandom_range(1, 70));
    end else begin
      build_frame(etype, proto, ihl, doff, tlen, pay);
    end
    keep = truncate ? $urandom_range(1, frame_buf.size()) : frame_buf.size();
    send_frame(keep);
    sent = keep;
  endtask

  task automatic wait_drained();
    while (wire_bytes.size() != 0 || in_valid || expected_headers.size() != 0)
      @(negedge clk);
  endtask

  task automatic directed_frames();
    // Frames cut short at the Ethernet, IPv4 and minimum TCP length checks.
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 16'd40, 0);
    send_frame(1);
    send_frame(13);
    send_frame(14);
    send_frame(33);
    send_frame(53);
    // Wrong EtherType, with part of the IPv4 header behind it.
    build_frame(16'h86DD, PROTO_TCP, 4'd5, 4'd5, 16'd40, 0);
    send_frame(20);
    // Protocol other than TCP, with just the IPv4 header captured.
    build_frame(TYPE_IPV4, 8'd17, 4'd5, 4'd5, 16'd40, 0);
    send_frame(34);
    // IP header lengths under the minimum; TCP fields then overlap IP fields.
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd0, 4'd5, 16'd40, 0);
    send_frame(40);
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd4, 4'd5, 16'd40, 0);
    send_frame(40);
    // TCP header lengths under the minimum.
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd5, 4'd0, 16'd40, 0);
    send_whole();
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd5, 4'd4, 16'd40, 0);
    send_whole();
    // TCP options cut off before the end of the TCP header.
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd6, 4'd8, 16'd56, 0);
    send_frame(60);
    // Good frames: exact payload, payload floored at zero, payload capped.
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 16'd50, 10);
    send_whole();
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 16'd0, 6);
    send_whole();
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 16'd1500, 5);
    send_whole();
    // Largest headers.
    build_frame(TYPE_IPV4, PROTO_TCP, 4'd15, 4'd15, 16'd123, 3);
    send_whole();
    // Extreme byte values throughout.
    fill_frame(8'h00, 20);
    send_whole();
    fill_frame(8'hFF, 20);
    send_whole();
  endtask

  // Stimulus, run on falling edges so that queue updates never share a
  // time step with the driver.
  initial begin
    int sent, bytes_sent, frames_sent;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 65; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 65; end
        default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
      endcase
      if (phase == 0) begin
        directed_frames();
        wait_drained();
        // Hold the receiver off while short frames keep coming, so that
        // finished frames back up and the input stalls.
        hold_requests++;
        build_frame(TYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 16'd40, 0);
        repeat (5) send_frame(20);
      end else begin
        bytes_sent = 0;
        frames_sent = 0;
        while (bytes_sent < 100 || frames_sent < 2) begin
          random_frame(sent);
          bytes_sent += sent;
          frames_sent++;
        end
      end
      wait_drained();
    end
    repeat (10) @(negedge clk);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
